// ===== sv/zor_pkg.sv =====
// Shared types and constants for the z-score outlier row unit.
package zor_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 24;
    localparam int ROW_INDEX_W = 6;
    localparam int COL_W       = 5;
    localparam int FC_RAW_W    = 5;
    localparam int FC_W        = 6;
    localparam int LIMIT_W     = 16;
    localparam int SPREAD_W    = 25;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int BOUND_W     = LIMIT_W + SPREAD_W;
    localparam int LIMIT_FRAC  = 8;
    localparam int MAG_SH_W    = DIFF_W + LIMIT_FRAC;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEATURE_COUNT   = 2'd0,
        CFG_LABEL_PRESENT   = 2'd1,
        CFG_DEVIATION_LIMIT = 2'd2
    } zor_cfg_idx_t;

    // Register reset values
    localparam logic [FC_RAW_W-1:0] FEATURE_COUNT_RST   = 5'd1;
    localparam logic                LABEL_PRESENT_RST   = 1'b0;
    localparam logic [LIMIT_W-1:0]  DEVIATION_LIMIT_RST = 16'd768;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic set_clear;
        logic f_clear;
        logic f_inc;
        logic r_clear;
        logic r_inc;
        logic sum_clear;
        logic sum_acc;
        logic div_mean;
        logic div_var;
        logic div_step;
        logic mean_wr;
        logic sq_clear;
        logic sq_mul;
        logic sq_acc;
        logic sqrt_start;
        logic sqrt_step;
        logic bound_wr;
        logic flag_clear;
        logic flag_cmp;
    } zor_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_last;
        logic rows_ready;
        logic last_row;
        logic last_feat;
        logic div_last;
        logic sqrt_last;
    } zor_status_t;

endpackage

// ===== sv/zor_ifs.sv =====
// Channel interfaces: sample input, verdict output, configuration writes.
interface zor_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [zor_pkg::SAMPLE_W-1:0]  sample;
    logic                                 last_of_set;

    modport source (output valid, output sample, output last_of_set, input ready);
    modport sink   (input valid, input sample, input last_of_set, output ready);
endinterface

interface zor_out_if;
    logic                                valid;
    logic                                ready;
    logic [zor_pkg::ROW_INDEX_W-1:0]     row_index;
    logic                                is_outlier;
    logic                                last;

    modport source (output valid, output row_index, output is_outlier, output last,
                     input ready);
    modport sink   (input valid, input row_index, input is_outlier, input last,
                     output ready);
endinterface

interface zor_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [zor_pkg::CFG_IDX_W-1:0]      index;
    logic [zor_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/zor_ctrl.sv =====
// Controller state machine: load, per-feature statistics, per-row verdicts.
module zor_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  zor_pkg::zor_status_t status,
    output zor_pkg::zor_cmd_t    cmd
);

    typedef enum logic [16:0] {
        S_LOAD    = 17'b00000000000000001,
        S_SUM_RD  = 17'b00000000000000010,
        S_SUM_ACC = 17'b00000000000000100,
        S_MSTART  = 17'b00000000000001000,
        S_MDIV    = 17'b00000000000010000,
        S_MEAN    = 17'b00000000000100000,
        S_SQ_RD   = 17'b00000000001000000,
        S_SQ_MUL  = 17'b00000000010000000,
        S_SQ_ACC  = 17'b00000000100000000,
        S_VSTART  = 17'b00000001000000000,
        S_VDIV    = 17'b00000010000000000,
        S_RSTART  = 17'b00000100000000000,
        S_SQRT    = 17'b00001000000000000,
        S_BOUND   = 17'b00010000000000000,
        S_VR_RD   = 17'b00100000000000000,
        S_VR_CMP  = 17'b01000000000000000,
        S_EMIT    = 17'b10000000000000000
    } zor_state_t;

    zor_state_t state_reg;
    zor_state_t state_next;

    // Handshakes
    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && status.in_last && status.rows_ready)
                begin
                    cmd.f_clear   = 1'b1;
                    cmd.r_clear   = 1'b1;
                    cmd.sum_clear = 1'b1;
                    state_next    = S_SUM_RD;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (status.last_row)
                begin
                    state_next = S_MSTART;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_SUM_RD;
                end
            end
            S_MSTART:
            begin
                cmd.div_mean = 1'b1;
                state_next   = S_MDIV;
            end
            S_MDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.mean_wr  = 1'b1;
                cmd.r_clear  = 1'b1;
                cmd.sq_clear = 1'b1;
                state_next   = S_SQ_RD;
            end
            S_SQ_RD:
            begin
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.sq_acc = 1'b1;
                if (status.last_row)
                begin
                    state_next = S_VSTART;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_SQ_RD;
                end
            end
            S_VSTART:
            begin
                cmd.div_var = 1'b1;
                state_next  = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = S_BOUND;
                end
            end
            S_BOUND:
            begin
                cmd.bound_wr = 1'b1;
                cmd.r_clear  = 1'b1;
                if (status.last_feat)
                begin
                    cmd.f_clear    = 1'b1;
                    cmd.flag_clear = 1'b1;
                    state_next     = S_VR_RD;
                end
                else
                begin
                    cmd.f_inc     = 1'b1;
                    cmd.sum_clear = 1'b1;
                    state_next    = S_SUM_RD;
                end
            end
            S_VR_RD:
            begin
                state_next = S_VR_CMP;
            end
            S_VR_CMP:
            begin
                cmd.flag_cmp = 1'b1;
                if (status.last_feat)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.f_inc  = 1'b1;
                    state_next = S_VR_RD;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.last_row)
                    begin
                        cmd.set_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.r_inc      = 1'b1;
                        cmd.f_clear    = 1'b1;
                        cmd.flag_clear = 1'b1;
                        state_next     = S_VR_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/zor_dp.sv =====
// Datapath: sample store, config registers, divider, square root, verdict compare.
module zor_dp #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_FEATURES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  zor_pkg::zor_cmd_t                    cmd,
    output zor_pkg::zor_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [zor_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [zor_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [zor_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic                                 in_last,
    output logic [zor_pkg::ROW_INDEX_W-1:0]      out_row_index,
    output logic                                 out_is_outlier,
    output logic                                 out_last
);

    localparam int RI_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FI_W     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int RC_W     = $clog2(MAX_ROWS + 1);
    localparam int DEPTH    = MAX_ROWS * MAX_FEATURES;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W    = zor_pkg::SAMPLE_W + RC_W - 1;
    localparam int SQ_W     = 2 * zor_pkg::SAMPLE_W + RC_W + 1;
    localparam int SQRT_TOP = ((SQ_W - 1) / 2) * 2;
    localparam int DC_W     = $clog2(SQ_W);

    // Configuration registers
    logic [zor_pkg::FC_RAW_W-1:0] feature_count_reg;
    logic                         label_present_reg;
    logic [zor_pkg::LIMIT_W-1:0]  deviation_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg   <= zor_pkg::FEATURE_COUNT_RST;
            label_present_reg   <= zor_pkg::LABEL_PRESENT_RST;
            deviation_limit_reg <= zor_pkg::DEVIATION_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zor_pkg::CFG_FEATURE_COUNT:
                    feature_count_reg <= cfg_data[zor_pkg::FC_RAW_W-1:0];
                zor_pkg::CFG_LABEL_PRESENT:
                    label_present_reg <= cfg_data[0];
                zor_pkg::CFG_DEVIATION_LIMIT:
                    deviation_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clamp feature count to 1..MAX_FEATURES and form the row width
    logic [zor_pkg::FC_W-1:0] fc;
    logic [zor_pkg::FC_W-1:0] row_width;

    always_comb
    begin
        if (feature_count_reg == '0)
            fc = zor_pkg::FC_W'(1);
        else if (zor_pkg::FC_W'(feature_count_reg) > zor_pkg::FC_W'(MAX_FEATURES))
            fc = zor_pkg::FC_W'(MAX_FEATURES);
        else
            fc = zor_pkg::FC_W'(feature_count_reg);
        row_width = fc + zor_pkg::FC_W'(label_present_reg);
    end

    // Load counters
    logic [RC_W-1:0]             row_count_reg;
    logic [RC_W-1:0]             row_count_next;
    logic [zor_pkg::COL_W-1:0]   col_reg;
    logic [zor_pkg::COL_W-1:0]   col_next;
    logic [zor_pkg::FC_W-1:0]    col_inc;
    logic                        row_full;
    logic                        row_close;
    logic                        store_we;

    always_comb
    begin
        col_inc   = zor_pkg::FC_W'(col_reg) + zor_pkg::FC_W'(1);
        row_full  = (row_count_reg >= RC_W'(MAX_ROWS));
        row_close = (col_inc >= row_width);
        store_we  = cmd.load && (zor_pkg::FC_W'(col_reg) < fc) && !row_full;
        row_count_next = row_count_reg;
        col_next       = col_reg;
        if (cmd.load)
        begin
            if (row_close && !row_full)
                row_count_next = row_count_reg + RC_W'(1);
            if (row_close || in_last)
                col_next = '0;
            else
                col_next = col_inc[zor_pkg::COL_W-1:0];
        end
        if (cmd.set_clear)
        begin
            row_count_next = '0;
            col_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_reg       <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_reg       <= col_next;
        end
    end

    // Pass counters: row and feature
    logic [RI_W-1:0] r_cnt_reg;
    logic [FI_W-1:0] f_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_cnt_reg <= '0;
            f_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.r_clear)
                r_cnt_reg <= '0;
            else if (cmd.r_inc)
                r_cnt_reg <= r_cnt_reg + RI_W'(1);
            if (cmd.f_clear)
                f_cnt_reg <= '0;
            else if (cmd.f_inc)
                f_cnt_reg <= f_cnt_reg + FI_W'(1);
        end
    end

    // Sample store: one write port for loading, one registered read port
    logic signed [zor_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
    logic signed [zor_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]                       waddr;
    logic [AW-1:0]                       raddr;

    assign waddr = AW'(int'(row_count_reg[RI_W-1:0]) * MAX_FEATURES
                       + int'(col_reg[FI_W-1:0]));
    assign raddr = AW'(int'(r_cnt_reg) * MAX_FEATURES + int'(f_cnt_reg));

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[waddr] <= in_sample;
        rd_data_reg <= store_mem[raddr];
    end

    // Column sum
    logic signed [SUM_W-1:0] sum_reg;
    logic        [SUM_W-1:0] sum_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_acc)
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
    end

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // Shared restoring divider by the row count, one quotient bit per step
    logic [SQ_W-1:0] dvd_reg;
    logic [RC_W-1:0] rem_reg;
    logic [DC_W-1:0] div_cnt_reg;
    logic            div_neg_reg;
    logic [RC_W:0]   rem_sh;
    logic            rem_ge;
    logic [SQ_W-1:0] sq_acc_reg;

    assign rem_sh = {rem_reg, dvd_reg[SQ_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, row_count_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_mean)
        begin
            dvd_reg     <= SQ_W'(sum_mag);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            div_neg_reg <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_var)
        begin
            dvd_reg     <= sq_acc_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            div_neg_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg     <= {dvd_reg[SQ_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? RC_W'(rem_sh - {1'b0, row_count_reg})
                                  : RC_W'(rem_sh);
            div_cnt_reg <= div_cnt_reg + DC_W'(1);
        end
    end

    // Feature means, written after the mean division
    logic signed [zor_pkg::SAMPLE_W-1:0] mean_mem [MAX_FEATURES];
    logic        [zor_pkg::SAMPLE_W-1:0] quot_lo;

    assign quot_lo = dvd_reg[zor_pkg::SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mean_wr)
            mean_mem[f_cnt_reg] <= div_neg_reg ? -quot_lo : quot_lo;
    end

    // Deviation of the read sample from its column mean
    logic signed [zor_pkg::DIFF_W-1:0]     diff;
    logic signed [2*zor_pkg::DIFF_W-1:0]   diff_sq;
    logic        [zor_pkg::DIFF_W-1:0]     diff_mag;

    always_comb
    begin
        diff     = zor_pkg::DIFF_W'(rd_data_reg) - zor_pkg::DIFF_W'(mean_mem[f_cnt_reg]);
        diff_sq  = diff * diff;
        diff_mag = diff[zor_pkg::DIFF_W-1] ? zor_pkg::DIFF_W'(-diff)
                                           : zor_pkg::DIFF_W'(diff);
    end

    // Squared deviation product and accumulator
    logic [zor_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
            prod_reg <= diff_sq[zor_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_acc_reg <= '0;
        else if (cmd.sq_clear || cmd.set_clear)
            sq_acc_reg <= '0;
        else if (cmd.sq_acc)
            sq_acc_reg <= sq_acc_reg + SQ_W'(prod_reg);
    end

    // Bitwise floor square root, two radicand bits per step
    logic [SQ_W-1:0] sqv_reg;
    logic [SQ_W-1:0] root_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] root_try;

    assign root_try = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sqv_reg  <= dvd_reg;
            root_reg <= '0;
            bit_reg  <= SQ_W'(1) << SQRT_TOP;
        end
        else if (cmd.sqrt_step)
        begin
            if (sqv_reg >= root_try)
            begin
                sqv_reg  <= sqv_reg - root_try;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Per-feature bound: deviation_limit times spread, Q33.8
    logic [zor_pkg::BOUND_W-1:0] bound_mem [MAX_FEATURES];

    always_ff @(posedge clk)
    begin
        if (cmd.bound_wr)
            bound_mem[f_cnt_reg] <= zor_pkg::BOUND_W'(deviation_limit_reg)
                                    * zor_pkg::BOUND_W'(root_reg[zor_pkg::SPREAD_W-1:0]);
    end

    // Outlier flag: accumulate over the features of the current row
    logic                         flag_reg;
    logic [zor_pkg::MAG_SH_W-1:0] mag_sh;
    logic                         exceed;

    assign mag_sh = {diff_mag, {zor_pkg::LIMIT_FRAC{1'b0}}};
    assign exceed = (zor_pkg::BOUND_W'(mag_sh) > bound_mem[f_cnt_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b0;
        else if (cmd.flag_clear)
            flag_reg <= 1'b0;
        else if (cmd.flag_cmp)
            flag_reg <= flag_reg | exceed;
    end

    // Status back to the controller; rows_ready assumes the offered sample transfers
    always_comb
    begin
        status.in_last    = in_last;
        status.rows_ready = (row_count_reg != '0) || (row_close && !row_full);
        status.last_row   = (RC_W'(r_cnt_reg) == row_count_reg - RC_W'(1));
        status.last_feat  = (zor_pkg::FC_W'(f_cnt_reg) == fc - zor_pkg::FC_W'(1));
        status.div_last   = (div_cnt_reg == DC_W'(SQ_W - 1));
        status.sqrt_last  = bit_reg[0];
    end

    // Verdict payload
    assign out_row_index  = zor_pkg::ROW_INDEX_W'(r_cnt_reg);
    assign out_is_outlier = flag_reg;
    assign out_last       = status.last_row;

endmodule

// ===== sv/zscore_outlier_rows_unit.sv =====
// Top level of the z-score outlier row unit: controller plus datapath.
//
//  channel    role    transfer moves
//  samples    sink    sample (Q12.12), last_of_set
//  verdicts   source  row_index, is_outlier, last
//  cfg        sink    index, data (always ready)
//
// Loading takes one sample per cycle. At set end, each feature in turn runs
// through the sums, the squared deviations, two passes of the bit-serial
// divider (mean, then variance) and the square root; the verdicts then follow
// row by row, each held until the verdict is taken. The single store read port
// sets the per-row cost. Reset clears counters and restores register defaults.
module zscore_outlier_rows_unit #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_FEATURES = 16
) (
    input logic       clk,
    input logic       rst_n,
    zor_in_if.sink    samples,
    zor_out_if.source verdicts,
    zor_cfg_if.sink   cfg
);

    zor_pkg::zor_cmd_t    cmd;
    zor_pkg::zor_status_t status;

    // Configuration is taken at any time
    assign cfg.ready = 1'b1;

    zor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (verdicts.valid),
        .out_ready (verdicts.ready),
        .status    (status),
        .cmd       (cmd)
    );

    zor_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .in_sample      (samples.sample),
        .in_last        (samples.last_of_set),
        .out_row_index  (verdicts.row_index),
        .out_is_outlier (verdicts.is_outlier),
        .out_last       (verdicts.last)
    );

endmodule

// ===== sv/zor_checker.sv =====
// Port-level checks for the z-score outlier row unit, bound to the top level.
module zor_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [zor_pkg::ROW_INDEX_W-1:0]  out_row_index,
    input logic                             out_last
);

    // Hold verdict payload while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_row_index)
                                       && $stable(out_last)))
    else $error("verdict changed while stalled");

    // Never load samples while a verdict is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input ready while verdict pending");

    // After the final verdict, return to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("no return to loading after final verdict");

    // Mid-set verdict keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("input reopened before final verdict");

endmodule

bind zscore_outlier_rows_unit zor_checker u_zor_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (samples.ready),
    .out_valid     (verdicts.valid),
    .out_ready     (verdicts.ready),
    .out_row_index (verdicts.row_index),
    .out_last      (verdicts.last)
);
